### rtl/spt_pkg.sv
// Shared types and constants for the spike train playback scheduler.
`default_nettype none

package spt_pkg;

   localparam int unsigned CHANNEL_W = 5;
   localparam int unsigned SLOT_W    = 6;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned COUNT_W   = 7;
   localparam int unsigned NUMCH_W   = 6;
   localparam int unsigned DELAY_W   = 20;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [TIME_W-1:0] NEVER = '1;

   localparam logic [NUMCH_W-1:0] NUMCH_RESET = 6'd32;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TICKS  = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_COUNT = 2'd1,
      REQ_TICK  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic                 push;
      logic                 flush;
      logic [CHANNEL_W-1:0] channel;
   } evt_cmd_type;

endpackage

`default_nettype wire

### rtl/spt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/spt_evt_out.sv
// Result stage: holds one fired event back to tag the last word of a tick.
`default_nettype none

module spt_evt_out (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spt_pkg::evt_cmd_type        evt_cmd,
   input  wire logic [spt_pkg::TIME_W-1:0]  deliver_time,
   output logic                             rsp_valid,
   output logic [spt_pkg::CHANNEL_W-1:0]    rsp_fired_channel,
   output logic [spt_pkg::TIME_W-1:0]       rsp_deliver_time,
   output logic                             rsp_last
);

   import spt_pkg::*;

   logic                 held_vld_ff, held_vld_in;
   logic [CHANNEL_W-1:0] held_ch_ff, held_ch_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] rsp_ch_ff, rsp_ch_in;
   logic [TIME_W-1:0]    rsp_time_ff, rsp_time_in;
   logic                 rsp_last_ff, rsp_last_in;

   always_comb begin
      held_vld_in  = held_vld_ff;
      held_ch_in   = held_ch_ff;
      rsp_valid_in = 1'b0;
      rsp_ch_in    = held_ch_ff;
      rsp_time_in  = deliver_time;
      rsp_last_in  = 1'b0;
      if (evt_cmd.push) begin
         rsp_valid_in = held_vld_ff;
         held_vld_in  = 1'b1;
         held_ch_in   = evt_cmd.channel;
      end else if (evt_cmd.flush) begin
         rsp_valid_in = held_vld_ff;
         rsp_last_in  = 1'b1;
         held_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ch_ff  <= held_ch_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_channel = rsp_ch_ff;
   assign rsp_deliver_time  = rsp_time_ff;
   assign rsp_last          = rsp_last_ff;

   a_push_flush_apart: assert property (@(posedge clock) disable iff (reset)
      !(evt_cmd.push && evt_cmd.flush))
      else $error("push and flush in the same cycle");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      evt_cmd.flush |=> !held_vld_ff)
      else $error("held event survived a flush");

   a_flush_tags_last: assert property (@(posedge clock) disable iff (reset)
      (evt_cmd.flush && held_vld_ff) |=> (rsp_valid && rsp_last))
      else $error("flush did not emit the last word");

endmodule

`default_nettype wire

### rtl/spike_train_playback_scheduler.sv
// Top level of the spike train playback scheduler: control, channel scan and stores.
//
// Usage:
//   Request channel: start with req_type, req_channel, req_slot, req_time_value and
//   req_spike_count; a word is taken at a clock edge with start high and busy low.
//   A load writes one spike time and leaves busy low. A count request reads slot 0
//   of its channel and arms it, busy through ST_COUNT_RD and ST_COUNT_WR.
//   A tick whose time has reached the earliest pending time scans all CHANNELS
//   channel entries, one per cycle through a three-stage read/modify/write pipe on
//   the channel state RAM and the spike time RAM, busy through ST_SCAN and ST_FINISH.
//   A tick that is not due, and an unknown request, leave busy low.
//   Result channel: one word per fired channel, rsp_valid high for one cycle; the
//   receiver cannot stall it. Words of a tick leave in channel order, the final one
//   with rsp_last set, in the same cycle that busy falls.
//   Configuration: csr_we, csr_index, csr_wdata; to be written only while busy is low
//   by the user, not enforced by the block. Reset clears all channels to empty and
//   unarmed, restores the register defaults; spike times hold no value until loaded.
`default_nettype none

module spike_train_playback_scheduler #(
   parameter int CHANNELS           = 32,
   parameter int SPIKES_PER_CHANNEL = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_type,
   input  wire logic [spt_pkg::CHANNEL_W-1:0] req_channel,
   input  wire logic [spt_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic [spt_pkg::TIME_W-1:0]    req_time_value,
   input  wire logic [spt_pkg::COUNT_W-1:0]   req_spike_count,
   output logic                               rsp_valid,
   output logic [spt_pkg::CHANNEL_W-1:0]      rsp_fired_channel,
   output logic [spt_pkg::TIME_W-1:0]         rsp_deliver_time,
   output logic                               rsp_last,
   input  wire logic                          csr_we,
   input  wire logic [spt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spt_pkg::DELAY_W-1:0]   csr_wdata
);

   import spt_pkg::*;

   localparam int CH_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int CHX    = CH_W > int'(CHANNEL_W) ? CH_W : int'(CHANNEL_W);
   localparam int LEN_W  = $clog2(SPIKES_PER_CHANNEL + 1);
   localparam int CW     = LEN_W > int'(COUNT_W) ? LEN_W : int'(COUNT_W);
   localparam int SPK_N  = CHANNELS * SPIKES_PER_CHANNEL;
   localparam int SA_W   = SPK_N > 1 ? $clog2(SPK_N) : 1;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  ptr;
      logic [TIME_W-1:0] pend;
   } chan_type;

   localparam int CS_W = $bits(chan_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT_RD,
      ST_COUNT_WR,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [SA_W-1:0] spike_addr(input logic [CH_W-1:0] ch,
                                                  input logic [LEN_W-1:0] pos);
      return SA_W'(ch) * SA_W'(SPIKES_PER_CHANNEL) + SA_W'(pos);
   endfunction

   state_type           state_ff, state_in;
   logic [NUMCH_W-1:0]  num_ch_ff, num_ch_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [TIME_W-1:0]   earliest_ff, earliest_in;
   logic [CHANNELS-1:0] chan_vld_ff, chan_vld_in;
   logic [CH_W-1:0]     cnt_ch_ff, cnt_ch_in;
   logic [LEN_W-1:0]    cnt_len_ff, cnt_len_in;
   logic [TIME_W-1:0]   tv_ff, tv_in;
   logic [TIME_W-1:0]   deliver_ff, deliver_in;
   logic [TIME_W-1:0]   min_ff, min_in;
   logic [CH_W:0]       rd_idx_ff, rd_idx_in;
   logic                s1_vld_ff, s1_vld_in;
   logic [CH_W-1:0]     s1_idx_ff, s1_idx_in;
   logic                s1_chv_ff, s1_chv_in;
   logic                s2_vld_ff, s2_vld_in;
   logic [CH_W-1:0]     s2_idx_ff, s2_idx_in;
   logic                s2_due_ff, s2_due_in;
   logic                s2_end_ff, s2_end_in;
   logic [LEN_W-1:0]    s2_len_ff, s2_len_in;
   logic [LEN_W-1:0]    s2_ptr_ff, s2_ptr_in;
   logic [TIME_W-1:0]   s2_pend_ff, s2_pend_in;

   logic                accept;
   logic                ch_ok;
   logic                slot_ok;
   logic [CHX-1:0]      req_ch_ext;
   logic [CH_W-1:0]     req_ch_idx;
   logic [LEN_W-1:0]    cnt_sat;
   logic [TIME_W:0]     deliver_sum;
   logic                tick_due;

   logic                spk_we;
   logic [SA_W-1:0]     spk_wr_addr;
   logic [SA_W-1:0]     spk_rd_addr;
   logic [TIME_W-1:0]   spk_rd_data;

   logic                cs_we;
   logic [CH_W-1:0]     cs_wr_addr;
   chan_type            cs_wr_data;
   logic [CH_W-1:0]     cs_rd_addr;
   logic [CS_W-1:0]     cs_rd_raw;
   chan_type            s1_chan;
   logic                s1_due;
   logic [LEN_W-1:0]    s1_next_ptr;
   logic [TIME_W-1:0]   s2_new_pend;
   logic [TIME_W-1:0]   s2_min;
   logic [TIME_W-1:0]   cnt_pend;
   logic [CHX-1:0]      s2_ch_ext;
   evt_cmd_type         evt_cmd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign req_ch_ext = CHX'(req_channel);
   assign req_ch_idx = req_ch_ext[CH_W-1:0];
   assign ch_ok      = 32'(req_channel) < 32'(CHANNELS);
   assign slot_ok    = 32'(req_slot) < 32'(SPIKES_PER_CHANNEL);
   assign cnt_sat    = (CW'(req_spike_count) > CW'(SPIKES_PER_CHANNEL))
                       ? LEN_W'(SPIKES_PER_CHANNEL) : LEN_W'(req_spike_count);
   assign deliver_sum = {1'b0, req_time_value} + (TIME_W + 1)'(delay_ff);
   assign tick_due    = (earliest_ff != NEVER) && (req_time_value >= earliest_ff);

   // spike time store
   assign spk_we      = accept && (req_type == REQ_LOAD) && ch_ok && slot_ok;
   assign spk_wr_addr = spike_addr(req_ch_idx, LEN_W'(req_slot));
   assign spk_rd_addr = (state_ff == ST_COUNT_RD) ? spike_addr(cnt_ch_ff, '0)
                                                  : spike_addr(s1_idx_ff, s1_next_ptr);

   spt_ram #(
      .WIDTH (TIME_W),
      .DEPTH (SPK_N)
   ) u_spike_ram (
      .clock   (clock),
      .wr_en   (spk_we),
      .wr_addr (spk_wr_addr),
      .wr_data (req_time_value),
      .rd_addr (spk_rd_addr),
      .rd_data (spk_rd_data)
   );

   // stage 1: channel state read back
   assign cs_rd_addr  = rd_idx_ff[CH_W-1:0];
   assign s1_chan     = s1_chv_ff ? chan_type'(cs_rd_raw)
                                  : chan_type'{len: '0, ptr: '0, pend: NEVER};
   assign s1_due      = s1_vld_ff && (s1_chan.pend != NEVER) && (tv_ff >= s1_chan.pend)
                        && (32'(s1_idx_ff) < 32'(num_ch_ff));
   assign s1_next_ptr = s1_chan.ptr + LEN_W'(1);

   // stage 2: new pending time and write back
   assign s2_new_pend = s2_due_ff ? (s2_end_ff ? NEVER : spk_rd_data) : s2_pend_ff;
   assign s2_min      = (s2_new_pend < min_ff) ? s2_new_pend : min_ff;
   assign cnt_pend    = (cnt_len_ff != '0) ? spk_rd_data : NEVER;
   assign s2_ch_ext   = CHX'(s2_idx_ff);

   always_comb begin
      cs_we      = 1'b0;
      cs_wr_addr = s2_idx_ff;
      cs_wr_data = '{len: s2_len_ff, ptr: s2_ptr_ff, pend: s2_new_pend};
      if (state_ff == ST_COUNT_WR) begin
         cs_we      = 1'b1;
         cs_wr_addr = cnt_ch_ff;
         cs_wr_data = '{len: cnt_len_ff, ptr: '0, pend: cnt_pend};
      end else if (s2_vld_ff && s2_due_ff) begin
         cs_we = 1'b1;
      end
   end

   spt_ram #(
      .WIDTH (CS_W),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_addr (cs_rd_addr),
      .rd_data (cs_rd_raw)
   );

   always_comb begin
      evt_cmd.push    = s2_vld_ff && s2_due_ff;
      evt_cmd.flush   = (state_ff == ST_FINISH);
      evt_cmd.channel = s2_ch_ext[CHANNEL_W-1:0];
   end

   spt_evt_out u_evt_out (
      .clock             (clock),
      .reset             (reset),
      .evt_cmd           (evt_cmd),
      .deliver_time      (deliver_ff),
      .rsp_valid         (rsp_valid),
      .rsp_fired_channel (rsp_fired_channel),
      .rsp_deliver_time  (rsp_deliver_time),
      .rsp_last          (rsp_last)
   );

   always_comb begin
      state_in    = state_ff;
      num_ch_in   = num_ch_ff;
      delay_in    = delay_ff;
      earliest_in = earliest_ff;
      chan_vld_in = chan_vld_ff;
      cnt_ch_in   = cnt_ch_ff;
      cnt_len_in  = cnt_len_ff;
      tv_in       = tv_ff;
      deliver_in  = deliver_ff;
      min_in      = min_ff;
      rd_idx_in   = rd_idx_ff;
      s1_vld_in   = 1'b0;
      s1_idx_in   = rd_idx_ff[CH_W-1:0];
      s1_chv_in   = chan_vld_ff[rd_idx_ff[CH_W-1:0]];
      s2_vld_in   = s1_vld_ff;
      s2_idx_in   = s1_idx_ff;
      s2_due_in   = s1_due;
      s2_end_in   = s1_next_ptr >= s1_chan.len;
      s2_len_in   = s1_chan.len;
      s2_ptr_in   = s1_due ? s1_next_ptr : s1_chan.ptr;
      s2_pend_in  = s1_chan.pend;

      if (csr_we) begin
         case (csr_index)
            CSR_NUM_CHANNELS: num_ch_in = csr_wdata[NUMCH_W-1:0];
            CSR_DELAY_TICKS:  delay_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_COUNT: begin
                     if (ch_ok) begin
                        cnt_ch_in  = req_ch_idx;
                        cnt_len_in = cnt_sat;
                        state_in   = ST_COUNT_RD;
                     end
                  end
                  REQ_TICK: begin
                     if (tick_due) begin
                        tv_in      = req_time_value;
                        deliver_in = deliver_sum[TIME_W] ? NEVER : deliver_sum[TIME_W-1:0];
                        min_in     = NEVER;
                        rd_idx_in  = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_COUNT_RD: begin
            state_in = ST_COUNT_WR;
         end
         ST_COUNT_WR: begin
            chan_vld_in[cnt_ch_ff] = 1'b1;
            if (cnt_pend < earliest_ff) begin
               earliest_in = cnt_pend;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (32'(rd_idx_ff) < 32'(CHANNELS)) begin
               s1_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + (CH_W + 1)'(1);
            end
            if (s2_vld_ff) begin
               min_in = s2_min;
               if (s2_due_ff) begin
                  chan_vld_in[s2_idx_ff] = 1'b1;
               end
               if (s2_idx_ff == CH_W'(CHANNELS - 1)) begin
                  earliest_in = s2_min;
                  state_in    = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         num_ch_ff   <= NUMCH_RESET;
         delay_ff    <= DELAY_RESET;
         earliest_ff <= NEVER;
         chan_vld_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         num_ch_ff   <= num_ch_in;
         delay_ff    <= delay_in;
         earliest_ff <= earliest_in;
         chan_vld_ff <= chan_vld_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
      end
      cnt_ch_ff  <= cnt_ch_in;
      cnt_len_ff <= cnt_len_in;
      tv_ff      <= tv_in;
      deliver_ff <= deliver_in;
      min_ff     <= min_in;
      rd_idx_ff  <= rd_idx_in;
      s1_idx_ff  <= s1_idx_in;
      s1_chv_ff  <= s1_chv_in;
      s2_idx_ff  <= s2_idx_in;
      s2_due_ff  <= s2_due_in;
      s2_end_ff  <= s2_end_in;
      s2_len_ff  <= s2_len_in;
      s2_ptr_ff  <= s2_ptr_in;
      s2_pend_ff <= s2_pend_in;
   end

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("scan pipeline active outside a scan");

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_LOAD)) |=> !busy)
      else $error("load request raised busy");

   a_no_ram_write_race: assert property (@(posedge clock) disable iff (reset)
      (cs_we && s1_vld_ff) |-> (cs_wr_addr != s1_idx_ff))
      else $error("channel state write collides with a pending read");

endmodule

`default_nettype wire
